// ----- hw/rtl/rprop_weight_update_top_macros.svh -----
// Assertion macros for the RPROP weight update block.
`ifndef RPROP_WEIGHT_UPDATE_TOP_MACROS_SVH
`define RPROP_WEIGHT_UPDATE_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define RPWU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define RPWU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rpwu_pkg.sv -----
// Shared types and constants of the RPROP weight update block.
`default_nettype none

package rpwu_pkg;

    localparam int NUM_WEIGHTS = 1024;
    localparam int ADDR_W      = $clog2(NUM_WEIGHTS);
    localparam int IDX_W       = 10;
    localparam int WEIGHT_W    = 32;
    localparam int STEP_W      = 31;
    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC   = 14;
    localparam int Q_FRAC      = 24;
    localparam int REL_W       = STEP_W + WEIGHT_W - Q_FRAC;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 31;

    localparam logic [STEP_W-1:0] STEP_SAT = {STEP_W{1'b1}};

    localparam logic [GAIN_W-1:0] RST_GAIN_UP        = 16'd19661;
    localparam logic [GAIN_W-1:0] RST_GAIN_DOWN      = 16'd5407;
    localparam logic [STEP_W-1:0] RST_STEP_MAX       = 31'd838860800;
    localparam logic [STEP_W-1:0] RST_STEP_MIN       = 31'd17;
    localparam logic [STEP_W-1:0] RST_RELATIVE_LIMIT = 31'd0;
    localparam logic [STEP_W-1:0] RST_INITIAL_STEP   = 31'd16777216;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_UP        = 3'd0,
        CFG_GAIN_DOWN      = 3'd1,
        CFG_STEP_MAX       = 3'd2,
        CFG_STEP_MIN       = 3'd3,
        CFG_RELATIVE_LIMIT = 3'd4,
        CFG_INITIAL_STEP   = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SGN_ZERO = 2'b00,
        SGN_POS  = 2'b01,
        SGN_NEG  = 2'b11
    } t_sign;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_up;
        logic [GAIN_W-1:0] gain_down;
        logic [STEP_W-1:0] step_max;
        logic [STEP_W-1:0] step_min;
        logic [STEP_W-1:0] relative_limit;
        logic [STEP_W-1:0] initial_step;
    } t_cfg;

    typedef struct packed {
        logic  used;
        t_sign sign;
    } t_meta;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_mem_rd;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [STEP_W-1:0] step;
        t_meta             meta;
    } t_mem_wr;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        t_sign             sign;
        logic              same;
        logic              opp;
    } t_step_res;

    typedef struct packed {
        logic [STEP_W-1:0]          step;
        logic signed [WEIGHT_W-1:0] weight;
        t_sign                      grad_sign;
    } t_s3;

endpackage

`default_nettype wire

// ----- hw/rtl/rpwu_if.sv -----
// Request and response stream interfaces of the RPROP weight update block.
`default_nettype none

interface rpwu_req_if import rpwu_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [IDX_W-1:0]           weight_index;
    logic signed [WEIGHT_W-1:0] weight;
    logic signed [WEIGHT_W-1:0] gradient;

    modport source (output valid, output weight_index, output weight, output gradient,
                    input ready);
    modport sink   (input valid, input weight_index, input weight, input gradient,
                    output ready);
endinterface

interface rpwu_rsp_if import rpwu_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [WEIGHT_W-1:0] new_weight;
    logic [STEP_W-1:0]          new_step;

    modport source (output valid, output new_weight, output new_step, input ready);
    modport sink   (input valid, input new_weight, input new_step, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rpwu_cfg_regs.sv -----
// Configuration register file of the RPROP weight update block.
`default_nettype none

module rpwu_cfg_regs import rpwu_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_up        <= RST_GAIN_UP;
            r_cfg.gain_down      <= RST_GAIN_DOWN;
            r_cfg.step_max       <= RST_STEP_MAX;
            r_cfg.step_min       <= RST_STEP_MIN;
            r_cfg.relative_limit <= RST_RELATIVE_LIMIT;
            r_cfg.initial_step   <= RST_INITIAL_STEP;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN_UP:        r_cfg.gain_up        <= i_cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_DOWN:      r_cfg.gain_down      <= i_cfg_wdata[GAIN_W-1:0];
                CFG_STEP_MAX:       r_cfg.step_max       <= i_cfg_wdata[STEP_W-1:0];
                CFG_STEP_MIN:       r_cfg.step_min       <= i_cfg_wdata[STEP_W-1:0];
                CFG_RELATIVE_LIMIT: r_cfg.relative_limit <= i_cfg_wdata[STEP_W-1:0];
                CFG_INITIAL_STEP:   r_cfg.initial_step   <= i_cfg_wdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- hw/rtl/rpwu_state_mem.sv -----
// Per-entry step and sign memories with the clearing sweep after reset.
`default_nettype none

module rpwu_state_mem import rpwu_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_mem_rd i_rd,
    input  wire t_mem_wr i_wr,
    output logic [STEP_W-1:0] o_rd_step,
    output t_meta        o_rd_meta,
    output logic         o_clr_busy
);

    logic [STEP_W-1:0] r_step_mem [NUM_WEIGHTS];
    t_meta             r_meta_mem [NUM_WEIGHTS];
    logic [STEP_W-1:0] r_rd_step;
    t_meta             r_rd_meta;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_cnt;

    logic              n_meta_we;
    logic [ADDR_W-1:0] n_meta_addr;
    t_meta             n_meta_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == ADDR_W'(NUM_WEIGHTS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        if (r_clr_busy) begin
            n_meta_we   = 1'b1;
            n_meta_addr = r_clr_cnt;
            n_meta_data = '{used: 1'b0, sign: SGN_ZERO};
        end else begin
            n_meta_we   = i_wr.en;
            n_meta_addr = i_wr.addr;
            n_meta_data = i_wr.meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_step_mem[i_wr.addr] <= i_wr.step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_meta_we) begin
            r_meta_mem[n_meta_addr] <= n_meta_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_step <= r_step_mem[i_rd.addr];
            r_rd_meta <= r_meta_mem[i_rd.addr];
        end
    end

    assign o_rd_step  = r_rd_step;
    assign o_rd_meta  = r_rd_meta;
    assign o_clr_busy = r_clr_busy;

endmodule

`default_nettype wire

// ----- hw/rtl/rpwu_step_calc.sv -----
// Step adaptation: gain multiply, saturation and limit for one entry.
`default_nettype none

module rpwu_step_calc import rpwu_pkg::*; (
    input  wire t_cfg               i_cfg,
    input  wire logic [STEP_W-1:0]  i_step,
    input  wire t_sign              i_last_sign,
    input  wire t_sign              i_grad_sign,
    input  wire logic [REL_W-1:0]   i_rel_prod,
    output t_step_res               o_res
);

    localparam int PROD_W   = STEP_W + GAIN_W;
    localparam int SCALED_W = PROD_W - GAIN_FRAC;

    logic                same;
    logic                opp;
    logic [GAIN_W-1:0]   gain;
    logic [PROD_W-1:0]   prod;
    logic [SCALED_W-1:0] scaled;
    logic [STEP_W-1:0]   scaled_sat;
    logic [STEP_W-1:0]   limit_rel;
    logic [STEP_W-1:0]   limit;

    assign same = (i_grad_sign != SGN_ZERO) && (i_last_sign != SGN_ZERO)
                  && (i_grad_sign == i_last_sign);
    assign opp  = (i_grad_sign != SGN_ZERO) && (i_last_sign != SGN_ZERO)
                  && (i_grad_sign != i_last_sign);

    assign gain       = same ? i_cfg.gain_up : i_cfg.gain_down;
    assign prod       = PROD_W'(i_step) * PROD_W'(gain);
    assign scaled     = prod[PROD_W-1:GAIN_FRAC];
    assign scaled_sat = (|scaled[SCALED_W-1:STEP_W]) ? STEP_SAT : scaled[STEP_W-1:0];

    assign limit_rel = (|i_rel_prod[REL_W-1:STEP_W]) ? STEP_SAT : i_rel_prod[STEP_W-1:0];
    assign limit     = (i_cfg.relative_limit != '0) ? limit_rel : i_cfg.step_max;

    always_comb begin
        o_res.same = same;
        o_res.opp  = opp;
        if (same) begin
            o_res.step = (scaled_sat < limit) ? scaled_sat : limit;
            o_res.sign = i_grad_sign;
        end else if (opp) begin
            o_res.step = (scaled_sat > i_cfg.step_min) ? scaled_sat : i_cfg.step_min;
            o_res.sign = SGN_ZERO;
        end else begin
            o_res.step = i_step;
            o_res.sign = i_grad_sign;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rpwu_weight_sat.sv -----
// Weight move stage and response output register.
`default_nettype none

module rpwu_weight_sat import rpwu_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_load,
    input  wire t_s3    i_data,
    output logic        o_free,
    rpwu_rsp_if.source  o_rsp
);

    localparam int SUM_W = WEIGHT_W + 1;

    logic                       r_v3;
    t_s3                        r_s3;
    logic                       r_ov;
    logic signed [WEIGHT_W-1:0] r_new_weight;
    logic [STEP_W-1:0]          r_new_step;

    logic                       n_out_free;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [WEIGHT_W-1:0] n_weight;

    assign n_out_free = !r_ov || o_rsp.ready;
    assign o_free     = !r_v3 || n_out_free;

    always_comb begin
        case (r_s3.grad_sign)
            SGN_POS: n_sum = SUM_W'(r_s3.weight) - $signed({2'b00, r_s3.step});
            SGN_NEG: n_sum = SUM_W'(r_s3.weight) + $signed({2'b00, r_s3.step});
            default: n_sum = SUM_W'(r_s3.weight);
        endcase
        if (n_sum[SUM_W-1] != n_sum[SUM_W-2]) begin
            n_weight = n_sum[SUM_W-1] ? {1'b1, {(WEIGHT_W-1){1'b0}}}
                                      : {1'b0, {(WEIGHT_W-1){1'b1}}};
        end else begin
            n_weight = n_sum[WEIGHT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (o_free) begin
                r_v3 <= i_load;
            end
            if (n_out_free) begin
                r_ov <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s3 <= i_data;
        end
        if (r_v3 && n_out_free) begin
            r_new_weight <= n_weight;
            r_new_step   <= r_s3.step;
        end
    end

    assign o_rsp.valid      = r_ov;
    assign o_rsp.new_weight = r_new_weight;
    assign o_rsp.new_step   = r_new_step;

endmodule

`default_nettype wire

// ----- hw/rtl/rprop_weight_update_top.sv -----
// Throughput: one request per cycle, also for back-to-back requests to the same entry,
// while o_rsp.ready does not stall the pipeline. Each request passes through memory read,
// forwarding, step update and the weight move into the output register.
// Reset: synchronous, active low; config registers take their defaults and a sweep over
// all 1024 entries clears the sign and used memory, with i_req.ready low until it ends.
// Configuration writes are taken during the sweep.
`default_nettype none

`include "rprop_weight_update_top_macros.svh"

module rprop_weight_update_top import rpwu_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    rpwu_req_if.sink                   i_req,
    rpwu_rsp_if.source                 o_rsp,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int RELF_W = STEP_W + WEIGHT_W;

    t_cfg              cfg;
    t_mem_rd           mem_rd;
    t_mem_wr           mem_wr;
    logic [STEP_W-1:0] rd_step;
    t_meta             rd_meta;
    logic              clr_busy;
    t_step_res         step_res;
    t_s3               s3_data;
    logic              s3_free;

    logic                       r_v1;
    logic [ADDR_W-1:0]          r_idx1;
    logic signed [WEIGHT_W-1:0] r_w1;
    logic [WEIGHT_W-1:0]        r_aw1;
    t_sign                      r_gs1;

    logic                       r_v2;
    logic [ADDR_W-1:0]          r_idx2;
    logic signed [WEIGHT_W-1:0] r_w2;
    t_sign                      r_gs2;
    logic [STEP_W-1:0]          r_step2;
    t_sign                      r_ls2;
    logic [REL_W-1:0]           r_rel2;

    logic                       r_wb_v;
    logic [ADDR_W-1:0]          r_wb_idx;
    logic [STEP_W-1:0]          r_wb_step;
    t_sign                      r_wb_sign;

    logic                n_accept;
    logic                n_adv1;
    logic                n_adv2;
    logic                n_s1_free;
    logic                n_s2_free;
    t_sign               n_gs;
    logic [WEIGHT_W-1:0] n_aw;
    logic [RELF_W-1:0]   n_rel_full;
    logic [STEP_W-1:0]   n_fwd_step;
    t_sign               n_fwd_sign;

    rpwu_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    rpwu_state_mem u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd       (mem_rd),
        .i_wr       (mem_wr),
        .o_rd_step  (rd_step),
        .o_rd_meta  (rd_meta),
        .o_clr_busy (clr_busy)
    );

    rpwu_step_calc u_step (
        .i_cfg       (cfg),
        .i_step      (r_step2),
        .i_last_sign (r_ls2),
        .i_grad_sign (r_gs2),
        .i_rel_prod  (r_rel2),
        .o_res       (step_res)
    );

    rpwu_weight_sat u_wsat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (n_adv2),
        .i_data  (s3_data),
        .o_free  (s3_free),
        .o_rsp   (o_rsp)
    );

    assign n_adv2    = r_v2 && s3_free;
    assign n_s2_free = !r_v2 || s3_free;
    assign n_adv1    = r_v1 && n_s2_free;
    assign n_s1_free = !r_v1 || n_s2_free;

    assign i_req.ready = n_s1_free && !clr_busy;
    assign n_accept    = i_req.valid && i_req.ready;

    assign n_gs = i_req.gradient[WEIGHT_W-1] ? SGN_NEG
                : ((|i_req.gradient) ? SGN_POS : SGN_ZERO);
    assign n_aw = i_req.weight[WEIGHT_W-1] ? (~i_req.weight + 1'b1) : i_req.weight;

    assign mem_rd.en   = n_accept;
    assign mem_rd.addr = i_req.weight_index[ADDR_W-1:0];

    assign mem_wr.en   = n_adv2;
    assign mem_wr.addr = r_idx2;
    assign mem_wr.step = step_res.step;
    assign mem_wr.meta = '{used: 1'b1, sign: step_res.sign};

    assign n_rel_full = RELF_W'(r_aw1) * RELF_W'(cfg.relative_limit);

    always_comb begin
        if (r_v2 && (r_idx2 == r_idx1)) begin
            n_fwd_step = step_res.step;
            n_fwd_sign = step_res.sign;
        end else if (r_wb_v && (r_wb_idx == r_idx1)) begin
            n_fwd_step = r_wb_step;
            n_fwd_sign = r_wb_sign;
        end else if (rd_meta.used) begin
            n_fwd_step = rd_step;
            n_fwd_sign = rd_meta.sign;
        end else begin
            n_fwd_step = cfg.initial_step;
            n_fwd_sign = SGN_ZERO;
        end
    end

    assign s3_data = '{step: step_res.step, weight: r_w2, grad_sign: r_gs2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_wb_v <= 1'b0;
        end else begin
            if (n_s1_free) begin
                r_v1 <= n_accept;
            end
            if (n_s2_free) begin
                r_v2 <= r_v1;
            end
            if (n_adv2) begin
                r_wb_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_idx1 <= i_req.weight_index[ADDR_W-1:0];
            r_w1   <= i_req.weight;
            r_aw1  <= n_aw;
            r_gs1  <= n_gs;
        end
        if (n_adv1) begin
            r_idx2  <= r_idx1;
            r_w2    <= r_w1;
            r_gs2   <= r_gs1;
            r_step2 <= n_fwd_step;
            r_ls2   <= n_fwd_sign;
            r_rel2  <= n_rel_full[RELF_W-1:Q_FRAC];
        end
        if (n_adv2) begin
            r_wb_idx  <= r_idx2;
            r_wb_step <= step_res.step;
            r_wb_sign <= step_res.sign;
        end
    end

    `RPWU_ASSERT_NOW(a_clear_pipe_empty, clr_busy, !(r_v1 || r_v2 || r_wb_v), "pipeline busy during clear sweep")
    `RPWU_ASSERT_NOW(a_shrink_floor, r_v2 && step_res.opp, (step_res.step >= cfg.step_min) && (step_res.sign == SGN_ZERO), "shrunk step below floor or sign kept")
    `RPWU_ASSERT_NOW(a_grow_cap, r_v2 && step_res.same && (cfg.relative_limit == '0), step_res.step <= cfg.step_max, "grown step above cap")
    `RPWU_ASSERT_NOW(a_s3_held, !s3_free, o_rsp.valid, "step stage held with no response waiting")

endmodule

`default_nettype wire
